// ===== rtl/core/scp_pkg.sv =====
package scp_pkg;

  localparam int unsigned DEFAULT_FIFO_DEPTH = 8;

  // ascii codes seen by the parser
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_POP     = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ENQUEUED  = 3'd1,
    EV_DROPPED   = 3'd2,
    EV_SPEED_SET = 3'd3,
    EV_POPPED    = 3'd4,
    EV_POP_EMPTY = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    POS_START  = 3'd0,
    POS_SECOND = 3'd1,
    POS_THIRD  = 3'd2,
    POS_FOURTH = 3'd3,
    POS_FIFTH  = 3'd4
  } parse_pos_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/serial_command_parser_with_fifo.sv =====
// channel  | dir | tdata                                      | tuser
// s_axis   | in  | [7:0] rx_byte                              | [1:0] op
// m_axis   | out | [7:0] command_byte, [14:8] speed_percent,  | [2:0] event_res
//          |     | [18:15] queue_count, [23:19] zero          |
//
// one item per cycle sustained while the output is not stalled; each transfer
// is held in the input register and its result is then registered in the output register
// rst_ni clears parse position, letter, digits, speed and the fifo pointers
// a stalled result holds the output register; the input register still
// takes a new transfer whenever the result ahead of it is free to move
module serial_command_parser_with_fifo #(
  parameter int unsigned FIFO_DEPTH = scp_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] command_byte, [14:8] speed_percent,
                                     // [18:15] queue_count
  output logic [2:0]  m_axis_tuser   // [2:0] event_res
);
  import scp_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  // handshake and pipeline control
  logic       s_fire;
  logic       out_free;
  logic       advance;
  logic       in_valid_q;
  logic [1:0] op_q;
  logic [7:0] byte_q;

  // parser state
  parse_pos_e pos_q, pos_d;
  logic [7:0] letter_q, letter_d;
  logic [3:0] tens_q, tens_d;
  logic [3:0] ones_q, ones_d;
  logic [6:0] speed_q, speed_d;

  // decode of the item in the input register
  op_e        op;
  logic       is_p;
  logic       is_digit;
  logic       is_letter;
  logic       is_lf;
  logic [3:0] digit;
  logic [3:0] rounded_tens;

  // per-item outcome
  event_e     ev;
  logic [7:0] cmd_byte;
  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;
  logic [7:0] fifo_head;
  logic [CW-1:0] count_next;
  logic [CW+3:0] count_ext;

  // output register
  logic       out_valid_q;
  event_e     out_ev_q;
  logic [7:0] out_cmd_q;
  logic [6:0] out_speed_q;
  logic [3:0] out_count_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign op        = op_e'(op_q);
  assign is_p      = (letter_q == CHAR_P);
  assign is_digit  = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign is_lf     = (byte_q == CHAR_LF);
  assign is_letter = (byte_q == CHAR_S) || (byte_q == CHAR_T) || (byte_q == CHAR_D) ||
                     (byte_q == CHAR_E) || (byte_q == CHAR_P);
  assign digit     = byte_q[3:0] - CHAR_ZERO[3:0];

  // round to the nearest ten: tens digit plus one when ones is five or more
  assign rounded_tens = tens_q + {3'b000, (ones_q >= 4'd5)};

  // next parse position and captured fields
  always_comb begin
    pos_d    = pos_q;
    letter_d = letter_q;
    tens_d   = tens_q;
    ones_d   = ones_q;
    speed_d  = speed_q;
    if (advance && (op == OP_RX_BYTE)) begin
      case (pos_q)
        POS_START: begin
          if (is_letter) begin
            letter_d = byte_q;
            pos_d    = POS_SECOND;
          end
        end
        POS_SECOND: begin
          if (is_p && !is_digit) begin
            pos_d = POS_START;
          end else begin
            if (is_p) tens_d = digit;
            pos_d = POS_THIRD;
          end
        end
        POS_THIRD: begin
          if (is_p) begin
            if (is_digit) begin
              ones_d = digit;
              pos_d  = POS_FOURTH;
            end else begin
              pos_d = POS_START;
            end
          end else if (is_lf) begin
            pos_d = POS_START;
          end else begin
            pos_d = POS_FOURTH;
          end
        end
        POS_FOURTH: pos_d = POS_FIFTH;
        default: begin
          if (is_p && is_lf) begin
            speed_d = 7'(rounded_tens) * 7'd10;
          end
          pos_d = POS_START;
        end
      endcase
    end
  end

  // event, fifo control and reported letter
  always_comb begin
    ev        = EV_NONE;
    cmd_byte  = 8'h00;
    fifo_ctrl = '0;
    if (advance) begin
      case (op)
        OP_RX_BYTE: begin
          if ((pos_q == POS_THIRD) && !is_p && is_lf) begin
            if (fifo_stat.full) begin
              ev = EV_DROPPED;
            end else begin
              ev             = EV_ENQUEUED;
              cmd_byte       = letter_q;
              fifo_ctrl.push = 1'b1;
            end
          end else if ((pos_q == POS_FIFTH) && is_p && is_lf) begin
            ev = EV_SPEED_SET;
          end
        end
        OP_POP: begin
          if (fifo_stat.empty) begin
            ev = EV_POP_EMPTY;
          end else begin
            ev            = EV_POPPED;
            cmd_byte      = fifo_head;
            fifo_ctrl.pop = 1'b1;
          end
        end
        OP_CLEAR: fifo_ctrl.clear = 1'b1;
        default: ev = EV_NONE;
      endcase
    end
  end

  scp_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fifo_ctrl),
    .wdata_i     (letter_q),
    .head_o      (fifo_head),
    .count_next_o(count_next),
    .stat_o      (fifo_stat)
  );

  // queue count is reported modulo sixteen
  assign count_ext = {4'b0000, count_next};

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_START;
      letter_q <= 8'h00;
      tens_q   <= 4'h0;
      ones_q   <= 4'h0;
      speed_q  <= 7'd0;
    end else begin
      pos_q    <= pos_d;
      letter_q <= letter_d;
      tens_q   <= tens_d;
      ones_q   <= ones_d;
      speed_q  <= speed_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ev_q    <= ev;
      out_cmd_q   <= cmd_byte;
      out_speed_q <= speed_d;
      out_count_q <= count_ext[3:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tdata  = {5'b00000, out_count_q, out_speed_q, out_cmd_q};

endmodule

// ===== rtl/core/scp_fifo.sv =====
module scp_fifo #(
  parameter int unsigned FIFO_DEPTH = scp_pkg::DEFAULT_FIFO_DEPTH,
  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scp_pkg::fifo_ctrl_t ctrl_i,
  input  logic [7:0]          wdata_i,
  output logic [7:0]          head_o,
  output logic [CW-1:0]       count_next_o,
  output scp_pkg::fifo_stat_t stat_o
);
  import scp_pkg::*;

  localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    rdata_q;
  logic [7:0]    byp_data_q;
  logic          byp_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end else if (ctrl_i.push) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      byp_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      // new head written in the same cycle it becomes the head
      byp_q    <= ctrl_i.push && (wr_ptr_q == rd_ptr_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    rdata_q    <= mem[rd_ptr_d];
    byp_data_q <= wdata_i;
  end

  assign head_o       = byp_q ? byp_data_q : rdata_q;
  assign count_next_o = count_d;
  assign stat_o.full  = (count_q == FULL_COUNT);
  assign stat_o.empty = (count_q == '0);

endmodule
